FILE: rtl/acwa_pkg.sv
package acwa_pkg;

  // Command codes carried by an input beat; the unused code acts as a lookup
  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_RESOLVED = 2'd1,
    CMD_FAILED   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_RESOLVE = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_t;

  // Register word addresses
  localparam logic REG_EXPIRY = 1'b0;

  // One input beat
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [47:0] mac;
    logic [31:0] now;
  } item_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result beat
  typedef struct packed {
    status_t     status;
    logic [47:0] mac;
  } res_t;

endpackage

FILE: rtl/acwa_ram.sv
module acwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/acwa_ctrl.sv
module acwa_ctrl #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acwa_pkg::item_t      item,
  input  logic [31:0]          expiry,
  output logic                 res_valid,
  input  logic                 res_ready,
  output acwa_pkg::res_t       res,
  output logic [IDX_W-1:0]     ram_addr,
  output logic                 ram_we,
  output acwa_pkg::entry_t     ram_wdata,
  input  acwa_pkg::entry_t     ram_rdata
);

  import acwa_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  item_t              item_r, item_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [47:0]        hit_mac_r, hit_mac_nxt;
  logic [31:0]        hit_stamp_r, hit_stamp_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  res_t               res_r, res_nxt;

  logic               match;
  logic               free;
  logic [IDX_W-1:0]   tgt;
  logic [32:0]        deadline;

  // Compare of the entry read back in the previous cycle
  assign match = chk_v_r && valid_r[chk_idx_r] && (ram_rdata.ip == item_r.addr);
  assign free  = chk_v_r && !valid_r[chk_idx_r];
  assign tgt   = found_r ? slot_r : free_idx_r;

  // Stamp plus expiry at 33 bits, no wrap
  assign deadline = {1'b0, hit_stamp_r} + {1'b0, expiry};

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Sequencer: scan, decide, write back, hand over
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = chk_v_r;
    chk_idx_nxt    = chk_idx_r;
    item_nxt       = item_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    hit_mac_nxt    = hit_mac_r;
    hit_stamp_nxt  = hit_stamp_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    res_nxt        = res_r;
    ram_addr       = cnt_r[IDX_W-1:0];
    ram_we         = 1'b0;
    ram_wdata      = '{ip: item_r.addr, mac: item_r.mac, stamp: item_r.now};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = item;
          cnt_nxt        = '0;
          chk_v_nxt      = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_v_nxt   = (cnt_r != LAST);
        chk_idx_nxt = cnt_r[IDX_W-1:0];
        if (match && !found_r) begin
          found_nxt     = 1'b1;
          slot_nxt      = chk_idx_r;
          hit_mac_nxt   = ram_rdata.mac;
          hit_stamp_nxt = ram_rdata.stamp;
        end
        if (free && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = chk_idx_r;
        end
        if (cnt_r == LAST) begin
          state_nxt = S_EVAL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EVAL: begin
        case (item_r.cmd)
          CMD_RESOLVED: begin
            if (found_r || free_found_r) begin
              ram_addr       = tgt;
              ram_we         = 1'b1;
              valid_nxt[tgt] = 1'b1;
              res_nxt        = '{status: ST_STORED, mac: item_r.mac};
            end else begin
              res_nxt = '{status: ST_FULL, mac: 48'd0};
            end
          end
          CMD_FAILED: begin
            if (found_r) begin
              valid_nxt[slot_r] = 1'b0;
            end
            res_nxt = '{status: ST_CLEARED, mac: 48'd0};
          end
          default: begin
            if (found_r && (deadline >= {1'b0, item_r.now})) begin
              res_nxt = '{status: ST_HIT, mac: hit_mac_r};
            end else begin
              res_nxt = '{status: ST_RESOLVE, mac: 48'd0};
            end
          end
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      chk_v_r      <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      chk_v_r      <= chk_v_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    item_r      <= item_nxt;
    slot_r      <= slot_nxt;
    hit_mac_r   <= hit_mac_nxt;
    hit_stamp_r <= hit_stamp_nxt;
    free_idx_r  <= free_idx_nxt;
    res_r       <= res_nxt;
  end

  // Only a successful resolution writes the table, and only once per beat
  a_write_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EVAL) && (item_r.cmd == CMD_RESOLVED))
    else $error("table write outside evaluation");

  // A waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while waiting");

  // A recorded match always points at a live entry
  a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) && found_r |-> valid_r[slot_r])
    else $error("matched slot not valid");

  // A free slot picked during the scan is really empty
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) && free_found_r |-> !valid_r[free_idx_r])
    else $error("free slot is occupied");

endmodule

FILE: rtl/arp_cache_with_aging_unit.sv
// IPv4-to-MAC table with aging. Each input beat (lookup, resolution
// succeeded, resolution failed) yields exactly one result beat. Entries sit
// in a single-port RAM and are scanned one per cycle through that one port;
// a new item is taken only once the scan, the evaluation and the hand-over
// of the last result are done. A finished result waits in the output
// register while the next item is taken. Valid bits are flip-flops cleared
// at reset, so no clearing pass is needed. expiry_seconds sits at byte
// address 0 and should be written only while the block is idle.
module arp_cache_with_aging_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_ipv4_addr,
  input  logic [47:0] in_resolved_mac,
  input  logic [31:0] in_now_seconds,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [47:0] out_mac_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import acwa_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0]      expiry_r, expiry_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  item_t            item;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic [IDX_W-1:0] ram_addr;
  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             reg_hit;

  assign item = '{cmd: cmd_t'(in_cmd), addr: in_ipv4_addr,
                  mac: in_resolved_mac, now: in_now_seconds};

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_EXPIRY);
  assign prdata  = reg_hit ? expiry_r : 32'd0;

  always_comb begin
    expiry_nxt = expiry_r;
    if (psel && penable && pwrite && reg_hit) begin
      expiry_nxt = pwdata;
    end
  end

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      expiry_r    <= expiry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_res_r.status;
  assign out_mac_out = out_res_r.mac;

  // Sequencer
  acwa_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item      (item),
    .expiry    (expiry_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_addr  (ram_addr),
    .ram_we    (ram_we),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Entry store: address, MAC and stamp side by side
  acwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

FILE: tb/arp_cache_with_aging_unit_tb.sv
module arp_cache_with_aging_unit_tb;
  import acwa_pkg::*;

  localparam int N_SLOTS = 16;
  localparam int LIMIT_CYCLES = 400000;
  // wait before a register write, with a margin over one item's scan
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE = 24;

  // reserved command code, handled as a lookup
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // byte addresses on the register port
  localparam logic [2:0] EXPIRY_ADDR = {REG_EXPIRY, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [47:0] mac;
    logic [31:0] now;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [31:0] in_ipv4_addr = '0;
  logic [47:0] in_resolved_mac = '0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [47:0] out_mac_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the cache contents and the expiry register
  bit          tbl_valid [N_SLOTS];
  logic [31:0] tbl_ip [N_SLOTS];
  logic [47:0] tbl_mac [N_SLOTS];
  logic [31:0] tbl_stamp [N_SLOTS];
  logic [31:0] expiry_cfg = '0;

  res_t        pending_q [$];
  res_t        head_res;
  int          err_count = 0;
  int          cycle_count = 0;

  // sender burst state
  int          burst_left = 0;
  // receiver stall state
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_run = 0;

  logic [31:0] addr_pool [POOL_SIZE];
  logic [31:0] clock_now;
  stim_row_t   dir_rows [19];

  arp_cache_with_aging_unit #(
    .ENTRIES(N_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_ipv4_addr(in_ipv4_addr),
    .in_resolved_mac(in_resolved_mac),
    .in_now_seconds(in_now_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_mac_out(out_mac_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Expected result of one beat; updates the shadow table as the block would
  function automatic res_t resolve_arp(logic [1:0] cmd, logic [31:0] addr, logic [47:0] mac,
                                       logic [31:0] now);
    res_t r;
    int   hit_idx;
    int   free_idx;
    r.status = ST_RESOLVE;
    r.mac = '0;
    hit_idx = -1;
    free_idx = -1;
    // walk downwards so the lowest-numbered slot wins
    for (int i = N_SLOTS - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_ip[i] == addr) hit_idx = i;
      if (!tbl_valid[i]) free_idx = i;
    end
    case (cmd)
      CMD_RESOLVED: begin
        if (hit_idx < 0) hit_idx = free_idx;
        if (hit_idx >= 0) begin
          tbl_valid[hit_idx] = 1'b1;
          tbl_ip[hit_idx] = addr;
          tbl_mac[hit_idx] = mac;
          tbl_stamp[hit_idx] = now;
          r.status = ST_STORED;
          r.mac = mac;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_FAILED: begin
        if (hit_idx >= 0) tbl_valid[hit_idx] = 1'b0;
        r.status = ST_CLEARED;
      end
      default: begin
        // stamp + expiry at 33 bits, no wrap
        if (hit_idx >= 0 &&
            ({1'b0, tbl_stamp[hit_idx]} + {1'b0, expiry_cfg}) >= {1'b0, now}) begin
          r.status = ST_HIT;
          r.mac = tbl_mac[hit_idx];
        end
      end
    endcase
    return r;
  endfunction

  // Drive one beat, wait for it to be taken, then maybe open a gap
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] addr,
                           input logic [47:0] mac, input logic [31:0] now,
                           input bit typed, input res_t typed_res);
    res_t pred;
    int   gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_ipv4_addr <= addr;
    in_resolved_mac <= mac;
    in_now_seconds <= now;
    do @(posedge clk); while (in_stall);
    pred = resolve_arp(cmd, addr, mac, now);
    pending_q.push_back(typed ? typed_res : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // occasional long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 9);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_all();
    if (in_valid) in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone quiet
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == EXPIRY_ADDR) expiry_cfg = data;
  endtask

  // Random traffic over a pool of addresses, with some stray addresses mixed in
  task automatic run_phase(input int count, input int pool_n, input int store_pct,
                           input int clear_pct, input int noise_pct);
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [31:0] now;
    logic [47:0] mac;
    int          r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < store_pct) cmd = CMD_RESOLVED;
      else if (r < store_pct + clear_pct) cmd = CMD_FAILED;
      else cmd = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_LOOKUP;
      if ($urandom_range(0, 99) < noise_pct) addr = $urandom;
      else addr = addr_pool[$urandom_range(0, pool_n - 1)];
      mac[47:32] = 16'($urandom);
      mac[31:0] = $urandom;
      // time creeps forward; lookups sit near the stamps so expiry is exercised
      if ($urandom_range(0, 3) == 0) clock_now = clock_now + $urandom_range(1, 3);
      if ($urandom_range(0, 19) == 0) now = $urandom;
      else now = clock_now - $urandom_range(0, 2);
      send_beat(cmd, addr, mac, now, 1'b0, '{ST_HIT, 48'h0});
      if ($urandom_range(0, 39) == 0) drain_all();
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d mac=%h", $time, out_status, out_mac_out);
        err_count++;
      end else begin
        head_res = pending_q.pop_front();
        if (out_status !== head_res.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, head_res.status,
                   out_status);
          err_count++;
        end
        if (out_mac_out !== head_res.mac) begin
          $display("%0t: mac mismatch expected=%h actual=%h", $time, head_res.mac,
                   out_mac_out);
          err_count++;
        end
      end
    end
  end

  // Receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // directed beats, expiry still at its reset value of zero
    dir_rows[0]  = '{CMD_LOOKUP, 32'h0000_0000, 48'h1234_5678_9abc, 32'h0, 1'b1,
                     '{ST_RESOLVE, 48'h0}};
    dir_rows[1]  = '{CMD_SPARE, 32'hffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, 1'b1,
                     '{ST_RESOLVE, 48'h0}};
    dir_rows[2]  = '{CMD_FAILED, 32'h1234_5678, 48'h0, 32'h0, 1'b1, '{ST_CLEARED, 48'h0}};
    dir_rows[3]  = '{CMD_RESOLVED, 32'h0000_0000, 48'hffff_ffff_ffff, 32'd100, 1'b1,
                     '{ST_STORED, 48'hffff_ffff_ffff}};
    dir_rows[4]  = '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 32'd100, 1'b1,
                     '{ST_HIT, 48'hffff_ffff_ffff}};
    // one second late with zero expiry
    dir_rows[5]  = '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 32'd101, 1'b1, '{ST_RESOLVE, 48'h0}};
    // refresh in place, new MAC taken
    dir_rows[6]  = '{CMD_RESOLVED, 32'h0000_0000, 48'h0, 32'd200, 1'b1, '{ST_STORED, 48'h0}};
    dir_rows[7]  = '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 32'd200, 1'b1, '{ST_HIT, 48'h0}};
    dir_rows[8]  = '{CMD_RESOLVED, 32'hffff_ffff, 48'h0123_4567_89ab, 32'hffff_ffff, 1'b1,
                     '{ST_STORED, 48'h0123_4567_89ab}};
    dir_rows[9]  = '{CMD_LOOKUP, 32'hffff_ffff, 48'h0, 32'hffff_ffff, 1'b1,
                     '{ST_HIT, 48'h0123_4567_89ab}};
    dir_rows[10] = '{CMD_SPARE, 32'hffff_ffff, 48'h0, 32'h0, 1'b1,
                     '{ST_HIT, 48'h0123_4567_89ab}};
    dir_rows[11] = '{CMD_FAILED, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{ST_CLEARED, 48'h0}};
    dir_rows[12] = '{CMD_LOOKUP, 32'h0000_0000, 48'h0, 32'd200, 1'b1, '{ST_RESOLVE, 48'h0}};
    // reuses the freed lowest slot
    dir_rows[13] = '{CMD_RESOLVED, 32'ha5a5_a5a5, 48'haaaa_5555_aaaa, 32'h0, 1'b1,
                     '{ST_STORED, 48'haaaa_5555_aaaa}};
    dir_rows[14] = '{CMD_LOOKUP, 32'ha5a5_a5a5, 48'h0, 32'h0, 1'b1,
                     '{ST_HIT, 48'haaaa_5555_aaaa}};
    dir_rows[15] = '{CMD_RESOLVED, 32'h5a5a_5a5a, 48'h5555_aaaa_5555, 32'hffff_fffe, 1'b0,
                     '{ST_HIT, 48'h0}};
    dir_rows[16] = '{CMD_LOOKUP, 32'h5a5a_5a5a, 48'h0, 32'hffff_ffff, 1'b0, '{ST_HIT, 48'h0}};
    dir_rows[17] = '{CMD_FAILED, 32'hffff_ffff, 48'h0, 32'h0, 1'b0, '{ST_HIT, 48'h0}};
    dir_rows[18] = '{CMD_LOOKUP, 32'hffff_ffff, 48'h0, 32'h0, 1'b0, '{ST_HIT, 48'h0}};

    for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].mac, dir_rows[i].now,
                dir_rows[i].typed, dir_rows[i].want);
    end

    // write to an unmapped word must leave expiry at zero
    write_reg(UNUSED_ADDR, $urandom);
    clock_now = $urandom;
    run_phase(50, 8, 35, 15, 10);

    // maximum expiry, time running over the top of the counter
    write_reg(EXPIRY_ADDR, 32'hffff_ffff);
    clock_now = 32'hffff_ff00;
    run_phase(70, 8, 35, 15, 10);

    // store-heavy over a wide pool so the table fills
    write_reg(EXPIRY_ADDR, $urandom_range(0, 15));
    clock_now = $urandom;
    run_phase(90, 20, 65, 5, 5);

    write_reg(EXPIRY_ADDR, 32'd1);
    run_phase(80, POOL_SIZE, 30, 25, 15);

    write_reg(EXPIRY_ADDR, $urandom);
    clock_now = $urandom;
    run_phase(80, POOL_SIZE, 40, 20, 20);

    write_reg(EXPIRY_ADDR, 32'd0);
    run_phase(80, 12, 35, 20, 10);

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acwa_pkg.sv
rtl/acwa_ram.sv
rtl/acwa_ctrl.sv
rtl/arp_cache_with_aging_unit.sv
tb/arp_cache_with_aging_unit_tb.sv
